>>> rtl/lls_pkg.sv
package lls_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int MASK_W          = 9;

  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'h008;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'h00C;

  localparam logic CFG_BIRTH   = 1'b0;
  localparam logic CFG_SURVIVE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_GEN   = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_GEN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_en;
    logic wr_en;
    logic clr;
    logic gen_start;
    logic gen_run;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  gen_last;
    logic  out_free;
  } dp_status_t;

endpackage

>>> rtl/lls_ctrl.sv
module lls_ctrl import lls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (status.func)
          FUNC_WRITE: state_next = ST_WRITE;
          FUNC_READ:  state_next = ST_FIN;
          FUNC_GEN:   state_next = ST_GEN;
          FUNC_CLEAR: state_next = ST_FIN;
        endcase
      end
      ST_WRITE: state_next = ST_FIN;
      ST_GEN: if (status.gen_last) state_next = ST_FIN;
      ST_FIN: if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.latch = s_tvalid;
      end
      ST_DISPATCH: begin
        cmd.rd_en = (status.func == FUNC_READ) || (status.func == FUNC_WRITE);
        cmd.clr = (status.func == FUNC_CLEAR);
        cmd.gen_start = (status.func == FUNC_GEN);
      end
      ST_WRITE: cmd.wr_en = 1'b1;
      ST_GEN: cmd.gen_run = 1'b1;
      ST_FIN: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/lls_dp.sv
module lls_dp import lls_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       s_tdata,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [MASK_W-1:0] cfg_data,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata
);

  localparam int W  = GRID_WIDTH;
  localparam int H  = GRID_HEIGHT;
  localparam int CW = $clog2(W);
  localparam int RW = $clog2(H);
  localparam int NW = $clog2(H + 4);

  func_t       func_q;
  logic [5:0]  col_q, row_q;
  logic        alive_q, inside_q;
  logic [MASK_W-1:0] birth_mask, survive_mask;

  logic [W-1:0] cmem [H];
  logic [W-1:0] imem [H];
  logic [H-1:0] cval, ival;
  logic [W-1:0] rc, ri;
  logic [W-1:0] tc, mc, bc, ti, mi, bi, r0c, r0i;
  logic [W-1:0] wdc, wdi, nxt, inc_c, inc_i;
  logic [NW-1:0] cnt;
  logic [RW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] cidx;
  logic          on_grid, rd_fire, wr_fire, wr_ins, shift;
  logic          m_alive, m_inside;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q   <= func_t'(s_tdata[1:0]);
      col_q    <= s_tdata[7:2];
      row_q    <= s_tdata[13:8];
      alive_q  <= s_tdata[14];
      inside_q <= s_tdata[15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= BIRTH_RESET;
      survive_mask <= SURVIVE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BIRTH) birth_mask <= cfg_data;
      else survive_mask <= cfg_data;
    end
  end

  assign on_grid = (32'(col_q) < W) && (32'(row_q) < H);
  assign cidx    = CW'(col_q);

  always_comb begin
    if (cmd.gen_run) rd_addr = (cnt == '0) ? RW'(H - 1) : RW'(cnt - NW'(1));
    else rd_addr = RW'(row_q);
  end
  assign rd_fire = cmd.rd_en || (cmd.gen_run && (cnt <= NW'(H)));

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      rc <= cmem[rd_addr] & {W{cval[rd_addr]}};
      ri <= imem[rd_addr] & {W{ival[rd_addr]}};
    end
  end

  always_comb begin
    wdc = rc;
    wdi = ri;
    wdc[cidx] = alive_q;
    wdi[cidx] = inside_q;
    wr_fire = 1'b0;
    wr_ins  = 1'b0;
    wr_addr = RW'(row_q);
    if (cmd.wr_en) begin
      wr_fire = on_grid;
      wr_ins  = 1'b1;
    end else if (cmd.gen_run && (cnt >= NW'(4))) begin
      wr_fire = 1'b1;
      wr_addr = RW'(cnt - NW'(4));
      wdc = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      cmem[wr_addr] <= wdc;
      if (wr_ins) imem[wr_addr] <= wdi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cval <= '0;
      ival <= '0;
    end else if (cmd.clr) begin
      cval <= '0;
    end else if (wr_fire) begin
      cval[wr_addr] <= 1'b1;
      if (wr_ins) ival[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.gen_start) cnt <= '0;
    else if (cmd.gen_run) cnt <= cnt + NW'(1);
  end

  assign shift = cmd.gen_run && (cnt >= NW'(1)) && (cnt <= NW'(H + 2));
  assign inc_c = (cnt == NW'(H + 2)) ? r0c : rc;
  assign inc_i = (cnt == NW'(H + 2)) ? r0i : ri;

  always_ff @(posedge clk) begin
    if (shift) begin
      tc <= mc; mc <= bc; bc <= inc_c;
      ti <= mi; mi <= bi; bi <= inc_i;
    end
    if (cmd.gen_run && (cnt == NW'(2))) begin
      r0c <= rc;
      r0i <= ri;
    end
  end

  always_comb begin
    logic [W-1:0] te, me, be;
    logic [3:0]   n;
    int           xl, xr;
    te = tc & ti;
    me = mc & mi;
    be = bc & bi;
    for (int x = 0; x < W; x++) begin
      xl = (x == 0) ? W - 1 : x - 1;
      xr = (x == W - 1) ? 0 : x + 1;
      n = 4'(te[xl]) + 4'(te[x]) + 4'(te[xr]) + 4'(me[xl]) + 4'(me[xr])
        + 4'(be[xl]) + 4'(be[x]) + 4'(be[xr]);
      nxt[x] = mi[x] & (mc[x] ? survive_mask[n] : birth_mask[n]);
    end
  end

  assign m_alive  = (func_q == FUNC_READ) && on_grid && rc[cidx];
  assign m_inside = (func_q == FUNC_READ) && on_grid && ri[cidx];

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {5'd0, 1'b1, m_inside, m_alive};
  end

  assign status.func     = func_q;
  assign status.gen_last = (cnt == NW'(H + 3));
  assign status.out_free = !m_tvalid || m_tready;

endmodule

>>> rtl/life_like_automaton_step.sv
// Life-like cellular automaton on a toroidal grid with a per-cell region map.
// Input stream s_*: one beat is one operation (write, read, advance, clear).
// Output stream m_*: exactly one result beat per input beat, in order.
// Config channel cfg_*: index 0 birth mask, 1 survive mask; always ready,
// write only while no operation is in flight.
// One operation is taken at a time; s_tready is high only when idle.
// Read and clear go from dispatch straight to finish; write passes a write state in between.
// Advance: the sequencer streams one grid row per cycle through a three-row
// window and writes each new row back through the single write port of the
// row memory.
// A finished result sits in the output register; while the receiver
// stalls it holds there and the next beat is accepted but not finished.
// Reset clears all cells and the region map through per-row valid bits,
// restores birth mask B3 and survive mask S23, and drops m_tvalid.
module life_like_automaton_step import lls_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // func[1:0] col[7:2] row_index[13:8] alive_in inside_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // alive_out inside_out op_done, zero fill
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [MASK_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lls_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> rtl/lls_checker.sv
module lls_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2] && (m_tdata[7:3] == 5'd0))
    else $error("result beat without done flag or with stray bits");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while busy");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind life_like_automaton_step lls_checker u_lls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lls_pkg::*;

  localparam int W = GRID_WIDTH_DEF;
  localparam int H = GRID_HEIGHT_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic in_region;
    logic alive;
  } cell_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [MASK_W-1:0] cfg_data;

  bit                cells  [H][W];
  bit                region [H][W];
  logic [MASK_W-1:0] born_rule;
  logic [MASK_W-1:0] keep_rule;
  cell_result_t      pending_reads[$];

  int send_idle_pct;
  int recv_stall_pct;
  int errors = 0;
  int beats_sent;
  int beats_checked = 0;
  int gens_run;
  int idle_cycles = 0;
  int win_row;
  int win_col;

  life_like_automaton_step dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic step_generation();
    bit nxt [H][W];
    int n;
    int ny;
    int nx;
    for (int y = 0; y < H; y++) begin
      for (int x = 0; x < W; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dy != 0 || dx != 0) begin
              ny = (y + H + dy) % H;
              nx = (x + W + dx) % W;
              if (region[ny][nx] && cells[ny][nx]) n++;
            end
          end
        end
        if (!region[y][x]) nxt[y][x] = 1'b0;
        else if (cells[y][x]) nxt[y][x] = keep_rule[n];
        else nxt[y][x] = born_rule[n];
      end
    end
    cells = nxt;
  endtask

  task automatic apply_op(func_t f, int c, int r, bit a, bit i);
    cell_result_t res;
    res = '0;
    case (f)
      FUNC_WRITE: begin
        cells[r][c]  = a;
        region[r][c] = i;
      end
      FUNC_READ: begin
        res.alive     = cells[r][c];
        res.in_region = region[r][c];
      end
      FUNC_GEN: begin
        step_generation();
        gens_run++;
      end
      default: begin
        for (int y = 0; y < H; y++)
          for (int x = 0; x < W; x++) cells[y][x] = 1'b0;
      end
    endcase
    pending_reads.push_back(res);
  endtask

  task automatic send_op(func_t f, int c, int r, bit a, bit i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {i, a, r[5:0], c[5:0], f};
    do @(posedge clk); while (!s_tready);
    apply_op(f, c, r, a, i);
    beats_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_rule(logic idx, logic [MASK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BIRTH) born_rule = val;
    else keep_rule = val;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cell_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        beats_checked++;
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          exp_res = pending_reads.pop_front();
          if (m_tdata !== {5'b0, 1'b1, exp_res.in_region, exp_res.alive}) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time,
                     {5'b0, 1'b1, exp_res.in_region, exp_res.alive}, m_tdata);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_op(FUNC_READ, 0, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, W - 1, H - 1, 1'b0, 1'b0);
    send_op(FUNC_GEN, 0, 0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_corners_and_wrap();
    send_op(FUNC_WRITE, 0, 0, 1'b1, 1'b1);
    send_op(FUNC_WRITE, W - 1, 0, 1'b1, 1'b1);
    send_op(FUNC_WRITE, 0, H - 1, 1'b1, 1'b1);
    send_op(FUNC_WRITE, W - 1, H - 1, 1'b0, 1'b1);
    send_op(FUNC_WRITE, 1, 1, 1'b1, 1'b0);
    send_op(FUNC_WRITE, 1, 0, 1'b0, 1'b1);
    send_op(FUNC_READ, 0, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, 1, 1, 1'b0, 1'b0);
    send_op(FUNC_READ, W - 1, H - 1, 1'b0, 1'b0);
    send_op(FUNC_GEN, 0, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, W - 1, H - 1, 1'b0, 1'b0);
    send_op(FUNC_READ, 1, 1, 1'b0, 1'b0);
    send_op(FUNC_READ, 0, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, 1, 0, 1'b0, 1'b0);
    send_op(FUNC_CLEAR, 0, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, 1, 0, 1'b0, 1'b0);
    send_op(FUNC_READ, 0, H - 1, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random_ops(int count);
    int pick;
    int r;
    int c;
    win_row = $urandom_range(H - 1);
    win_col = $urandom_range(W - 1);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      r = (win_row + $urandom_range(7)) % H;
      c = (win_col + $urandom_range(7)) % W;
      if (pick < 48)
        send_op(FUNC_WRITE, c, r, 1'($urandom_range(1)), $urandom_range(99) < 85);
      else if (pick < 78)
        send_op(FUNC_READ, c, r, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (pick < 90)
        send_op(FUNC_GEN, $urandom_range(W - 1), $urandom_range(H - 1),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (pick < 92)
        send_op(FUNC_CLEAR, $urandom_range(W - 1), $urandom_range(H - 1),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_op(func_t'($urandom_range(1)), $urandom_range(W - 1), $urandom_range(H - 1),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    drain();
  endtask

  task automatic test_rule_phase(logic [MASK_W-1:0] b, logic [MASK_W-1:0] s,
                                 int idle, int stall, int count);
    write_rule(CFG_BIRTH, b);
    write_rule(CFG_SURVIVE, s);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    test_random_ops(count);
  endtask

  initial begin
    beats_sent = 0;
    gens_run = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    born_rule = BIRTH_RESET;
    keep_rule = SURVIVE_RESET;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BIRTH;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_corners_and_wrap();
    test_rule_phase(BIRTH_RESET, SURVIVE_RESET, 0, 0, 400);
    test_rule_phase(9'h000, 9'h1FF, 87, 0, 400);
    test_rule_phase(9'h1FF, 9'h000, 0, 87, 400);
    test_rule_phase(9'($urandom_range(511)), 9'($urandom_range(511)), 27, 27, 300);
    test_rule_phase(9'h1FF, 9'h1FF, 27, 27, 150);
    test_rule_phase(9'h000, 9'h000, 0, 0, 100);

    $display("Covered %0d operation beats, %0d results checked, %0d generations,",
             beats_sent, beats_checked, gens_run);
    $display("across default, empty, full and random birth/survive rules with idle and stall.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lls_pkg.sv
rtl/lls_ctrl.sv
rtl/lls_dp.sv
rtl/life_like_automaton_step.sv
rtl/lls_checker.sv
bench/testbench.sv
